[design/lrlt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the locked-RMW line lock table.
package lrlt_pkg;

  localparam int REQ_W  = 4;
  localparam int LINE_W = 42;
  localparam int FUNC_W = 3;

  localparam logic [FUNC_W-1:0] FN_IFETCH = 3'd0;
  localparam logic [FUNC_W-1:0] FN_LOAD   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_STORE  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_ATOMIC = 3'd3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_WAIT_FULL = 2'd2,
    ST_LOCK_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic [REQ_W-1:0]  who;
    logic [LINE_W-1:0] line;
    logic              wr;
    status_t           status;
  } result_t;

  typedef struct packed {
    logic [REQ_W-1:0]  who;
    logic              lk;
    logic [1:0]        fn;
    logic [LINE_W-1:0] line;
  } wait_t;

  typedef struct packed {
    logic load;
    logic look;
    logic walk;
    logic walk_end;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic look_walk;
    logic look_flush;
    logic walk_done;
    logic walk_stall;
    logic out_can;
  } stat_t;

endpackage

[design/lrlt_if.sv]
`timescale 1ns / 1ps
// Request and completion channel interfaces.
interface lrlt_req_if import lrlt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  requester;
  logic [LINE_W-1:0] line_address;
  logic [FUNC_W-1:0] func;
  logic              locked_rmw;

  modport source (output valid, requester, line_address, func, locked_rmw, input ready);
  modport sink   (input valid, requester, line_address, func, locked_rmw, output ready);
endinterface

interface lrlt_done_if import lrlt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  done_requester;
  logic [LINE_W-1:0] done_line;
  logic              done_is_write;
  logic [1:0]        status;
  logic              last;

  modport source (output valid, done_requester, done_line, done_is_write, status, last,
                  input ready);
  modport sink   (input valid, done_requester, done_line, done_is_write, status, last,
                  output ready);
endinterface

[design/lrlt_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: sequences lookup, wait-list walk and final beat.
module lrlt_ctrl import lrlt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOOK  = 4'b0010,
    S_WALK  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load = req_valid;
        if (req_valid) state_next = S_LOOK;
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        if (stat.look_walk) state_next = S_WALK;
        else if (stat.look_flush) state_next = S_FLUSH;
        else state_next = S_IDLE;
      end
      S_WALK: begin
        if (stat.walk_done) begin
          cmd.walk_end = 1'b1;
          state_next   = S_FLUSH;
        end else begin
          cmd.walk = !stat.walk_stall;
        end
      end
      S_FLUSH: begin
        cmd.flush = stat.out_can;
        if (stat.out_can) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign req_ready = (state == S_IDLE);

endmodule

[design/lrlt_dp.sv]
`timescale 1ns / 1ps
// Datapath: request register, lock table, wait list and result staging.
module lrlt_dp import lrlt_pkg::*; #(
  parameter int LOCK_ENTRIES = 8,
  parameter int WAIT_DEPTH   = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [REQ_W-1:0]  in_who,
  input  logic [LINE_W-1:0] in_line,
  input  logic [FUNC_W-1:0] in_fn,
  input  logic              in_lk,
  output logic              out_valid,
  input  logic              out_ready,
  output result_t           out_res,
  output logic              out_last
);

  localparam int LIX = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
  localparam int CW  = $clog2(WAIT_DEPTH + 1);
  localparam int WIX = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;

  logic [REQ_W-1:0]  req_who;
  logic [LINE_W-1:0] req_line;
  logic [FUNC_W-1:0] req_fn;
  logic              req_lk;

  logic              lock_valid [LOCK_ENTRIES];
  logic [LINE_W-1:0] lock_line  [LOCK_ENTRIES];
  wait_t             wl         [WAIT_DEPTH];
  logic [CW-1:0]     wcount, k, w;
  logic              stopped;
  result_t           pend;

  logic           hit, free;
  logic [LIX-1:0] hit_idx, free_idx;
  logic           invalid, is_wr, must_wait, wl_full, lock_rd, unlock;
  wait_t          cur;
  logic           walk_done, match, out_can, push;

  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < LOCK_ENTRIES; i++) begin
      if (lock_valid[i] && lock_line[i] == req_line && !hit) begin
        hit     = 1'b1;
        hit_idx = LIX'(i);
      end
      if (!lock_valid[i] && !free) begin
        free     = 1'b1;
        free_idx = LIX'(i);
      end
    end
  end

  assign invalid   = req_fn[2];
  assign is_wr     = req_fn[1];
  assign must_wait = !invalid && hit && !(req_lk && is_wr);
  assign wl_full   = (wcount == CW'(WAIT_DEPTH));
  assign lock_rd   = !invalid && !must_wait && req_lk && !is_wr;
  assign unlock    = !invalid && hit && req_lk && is_wr;

  assign cur       = wl[k[WIX-1:0]];
  assign walk_done = (k == wcount);
  assign match     = !walk_done && !stopped && (cur.line == req_line);
  assign out_can   = !out_valid || out_ready;
  assign push      = (cmd.walk && match) || cmd.flush;

  assign stat.look_walk  = unlock;
  assign stat.look_flush = !(must_wait && !wl_full);
  assign stat.walk_done  = walk_done;
  assign stat.walk_stall = match && !out_can;
  assign stat.out_can    = out_can;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LOCK_ENTRIES; i++) lock_valid[i] <= 1'b0;
      wcount    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.look) begin
        if (must_wait && !wl_full) wcount <= wcount + CW'(1);
        if (lock_rd && free) lock_valid[free_idx] <= 1'b1;
        if (unlock) lock_valid[hit_idx] <= 1'b0;
      end
      // a reissued locked read relocks the line and stops further matches in the walk
      if (cmd.walk && match && cur.lk && !cur.fn[1]) lock_valid[free_idx] <= 1'b1;
      if (cmd.walk_end) wcount <= w;
      if (push) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload and walk pointers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_who  <= in_who;
      req_line <= in_line;
      req_fn   <= in_fn;
      req_lk   <= in_lk;
    end
    if (cmd.look) begin
      k       <= '0;
      w       <= '0;
      stopped <= 1'b0;
      if (invalid) begin
        pend <= '{who: req_who, line: req_line, wr: 1'b0, status: ST_INVALID};
      end else if (must_wait) begin
        pend <= '{who: req_who, line: req_line, wr: is_wr, status: ST_WAIT_FULL};
        if (!wl_full)
          wl[wcount[WIX-1:0]] <= '{who: req_who, lk: req_lk, fn: req_fn[1:0], line: req_line};
      end else if (lock_rd) begin
        if (free) begin
          lock_line[free_idx] <= req_line;
          pend <= '{who: req_who, line: req_line, wr: 1'b0, status: ST_OK};
        end else begin
          pend <= '{who: req_who, line: req_line, wr: 1'b0, status: ST_LOCK_FULL};
        end
      end else begin
        pend <= '{who: req_who, line: req_line, wr: is_wr, status: ST_OK};
      end
    end
    if (cmd.walk) begin
      k <= k + CW'(1);
      if (match) begin
        pend <= '{who: cur.who, line: req_line, wr: cur.fn[1], status: ST_OK};
        if (cur.lk && !cur.fn[1]) begin
          lock_line[free_idx] <= req_line;
          stopped             <= 1'b1;
        end
      end else begin
        // compact the list in place
        wl[w[WIX-1:0]] <= cur;
        w              <= w + CW'(1);
      end
    end
    if (push) begin
      out_res  <= pend;
      out_last <= cmd.flush;
    end
  end

endmodule

[design/locked_rmw_line_lock_table_unit.sv]
`timescale 1ns / 1ps
// Top level of the locked-RMW line lock table.
//  channel | dir | payload                                              | handshake
//  req     | in  | requester, line_address, func, locked_rmw            | valid/ready
//  rsp     | out | done_requester, done_line, done_is_write, status,last | valid/ready
// One request at a time: accept, lookup, then for an unlock a wait-list walk, then one final result beat.
// Unlock: walks the wait list, one wait entry per cycle while rsp is not stalled.
// A request that only joins the wait list gives no beat.
// Reset clears the lock valid bits, the wait count and the output valid flag.
// A stalled rsp stalls the walk; req is not taken until the final beat is loaded.
module locked_rmw_line_lock_table_unit import lrlt_pkg::*; #(
  parameter int LOCK_ENTRIES = 8,
  parameter int WAIT_DEPTH   = 16
) (
  input  logic        clk,
  input  logic        rst,
  lrlt_req_if.sink    req,
  lrlt_done_if.source rsp
);

  cmd_t    cmd;
  stat_t   stat;
  result_t res;

  lrlt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lrlt_dp #(
    .LOCK_ENTRIES (LOCK_ENTRIES),
    .WAIT_DEPTH   (WAIT_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_who    (req.requester),
    .in_line   (req.line_address),
    .in_fn     (req.func),
    .in_lk     (req.locked_rmw),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_res   (res),
    .out_last  (rsp.last)
  );

  assign rsp.done_requester = res.who;
  assign rsp.done_line      = res.line;
  assign rsp.done_is_write  = res.wr;
  assign rsp.status         = res.status;

endmodule

[design/lrlt_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the lock table unit, with its bind.
module lrlt_checker import lrlt_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [LINE_W-1:0] out_line,
  input logic              out_wr,
  input logic [1:0]        out_status,
  input logic              out_last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_line))
    else $error("result beat changed while stalled");

  a_no_take_midstep: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("request taken while a step still has results pending");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken back to back");

  a_invalid_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_INVALID |-> !out_wr && out_last)
    else $error("invalid-kind result malformed");

  a_lockfull_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_LOCK_FULL |-> !out_wr && out_last)
    else $error("lock-full result malformed");

endmodule

bind locked_rmw_line_lock_table_unit lrlt_checker u_lrlt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (req.valid),
  .in_ready   (req.ready),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .out_line   (rsp.done_line),
  .out_wr     (rsp.done_is_write),
  .out_status (rsp.status),
  .out_last   (rsp.last)
);
